// ===== sv/platform_shift_return_sequencer_unit_defines.svh =====
// Assertion helpers for the platform shift/return sequencer.
// Each macro expects clk and rst_n in scope.
`ifndef PLATFORM_SHIFT_RETURN_SEQUENCER_UNIT_DEFINES_SVH
`define PLATFORM_SHIFT_RETURN_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PSRS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PSRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/psrs_pkg.sv =====
`timescale 1ns / 1ps
package psrs_pkg;

  // active action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_SHIFT  = 3'd1;
  localparam logic [2:0] ACT_RETURN = 3'd2;
  localparam logic [2:0] ACT_SR     = 3'd3;
  localparam logic [2:0] ACT_SR2    = 3'd4;

  // sensor variants
  localparam logic [1:0] VAR_TWO   = 2'd0;
  localparam logic [1:0] VAR_THREE = 2'd1;
  localparam logic [1:0] VAR_FOUR  = 2'd2;
  localparam logic [1:0] VAR_OPEN  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_VARIANT      = 3'd0;
  localparam logic [2:0] CFG_RET_LOC_DLY  = 3'd1;
  localparam logic [2:0] CFG_RET_IDLE_DLY = 3'd2;
  localparam logic [2:0] CFG_SHF_LOC_DLY  = 3'd3;
  localparam logic [2:0] CFG_SHF_STOP_DLY = 3'd4;

  // phases common to every action
  localparam logic [4:0] PH_START   = 5'd0;
  // three-sensor shift
  localparam logic [4:0] PH3_STOP_WAIT = 5'd1;
  localparam logic [4:0] PH3_RETRACT   = 5'd2;
  localparam logic [4:0] PH3_IDLE_WAIT = 5'd3;
  localparam logic [4:0] PH3_SEEK      = 5'd4;
  localparam logic [4:0] PH3_LOC_WAIT  = 5'd5;
  localparam logic [4:0] PH3_FINAL     = 5'd6;
  localparam logic [4:0] PH3_BRAKE     = 5'd7;
  localparam logic [4:0] PH3_PUSH      = 5'd8;
  localparam logic [4:0] PH_BACKOFF    = 5'd20;
  // four-sensor shift
  localparam logic [4:0] PH4_LIM2_FALL = 5'd1;
  localparam logic [4:0] PH4_LOCATE    = 5'd2;
  localparam logic [4:0] PH4_LIM1      = 5'd3;
  // two-sensor and open-loop shift
  localparam logic [4:0] PH2_LOCATE    = 5'd1;
  localparam logic [4:0] PHO_COUNT     = 5'd1;
  // return
  localparam logic [4:0] PHR_FALL      = 5'd1;
  localparam logic [4:0] PHR_RETRACT   = 5'd2;
  localparam logic [4:0] PHR_ORIGIN    = 5'd3;
  // last phase of the shift-return programs
  localparam logic [4:0] PHS_LAST_ONE  = 5'd3;
  localparam logic [4:0] PHS_LAST_TWO  = 5'd7;

  localparam int IN_W  = 8;
  localparam int OUT_W = 24;

endpackage

// ===== sv/platform_shift_return_sequencer_unit.sv =====
`timescale 1ns / 1ps
`include "platform_shift_return_sequencer_unit_defines.svh"
// An input beat passes through the input register and then the result register.
// One beat per cycle unless the result register stalls; state updates once per beat.
// A stalled result register holds the input register, which then holds in_tready low.
// Reset (rst_n low, synchronous): both stages empty, sequencer idle, counters and
// valve/done marks zero, sensor_variant three-sensor, all delays zero.
module platform_shift_return_sequencer_unit
  import psrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // op[2:0], origin_sensor, limit_one_sensor, limit_two_sensor, locate_sensor, pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // shift_valve, shift_back_valve, locate_valve, busy_res, shift_done, return_done,
  // shift_return_done, shift_return_twice_done, platform_position[7:0],
  // steps_since_return[7:0]
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  logic            in_v_r;
  logic [6:0]      in_data_r;
  logic            out_v_r;
  logic [OUT_W-1:0] out_data_r;
  logic            adv;

  logic [1:0]  variant_r;
  logic [15:0] rl_delay_r, ri_delay_r, sl_delay_r;
  logic [7:0]  ss_delay_r;

  logic [4:0]  phase_r, phase_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic [7:0]  pos_r, pos_nxt, start_r, start_nxt;
  logic        vs_r, vs_nxt, vb_r, vb_nxt, vl_r, vl_nxt;
  logic        ds_r, ds_nxt, dr_r, dr_nxt, dsr_r, dsr_nxt, dsr2_r, dsr2_nxt;
  logic        prev_loc_r, prev_lim2_r;

  logic [2:0]  op;
  logic        origin, lim1, lim2, loc, loc_fall, lim2_fall;
  logic [4:0]  ph, sr_last;
  logic [16:0] wait_lim;
  logic        wd;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    op        = in_data_r[2:0];
    origin    = in_data_r[3];
    lim1      = in_data_r[4];
    lim2      = in_data_r[5];
    loc       = in_data_r[6];
    loc_fall  = prev_loc_r && !loc;
    lim2_fall = prev_lim2_r && !lim2;

    phase_nxt = phase_r;
    act_nxt   = act_r;
    wc_nxt    = wc_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    vs_nxt    = vs_r;
    vb_nxt    = vb_r;
    vl_nxt    = vl_r;
    ds_nxt    = ds_r;
    dr_nxt    = dr_r;
    dsr_nxt   = dsr_r;
    dsr2_nxt  = dsr2_r;

    // take a command only while idle
    if (act_r == ACT_NONE) begin
      if (op == ACT_SHIFT || op == ACT_RETURN ||
          ((op == ACT_SR || op == ACT_SR2) && variant_r == VAR_TWO)) begin
        act_nxt   = op;
        phase_nxt = PH_START;
        wc_nxt    = '0;
      end
    end

    ph = phase_nxt;
    case (ph)
      PH3_STOP_WAIT: wait_lim = {1'b0, rl_delay_r};
      PH3_IDLE_WAIT: wait_lim = {1'b0, ri_delay_r};
      PH3_LOC_WAIT:  wait_lim = {1'b0, sl_delay_r};
      PH3_BRAKE:     wait_lim = 17'({1'b0, ss_delay_r} + 9'd1);
      default:       wait_lim = '0;
    endcase
    wd = {1'b0, wc_nxt} >= wait_lim;
    sr_last = (act_nxt == ACT_SR2) ? PHS_LAST_TWO : PHS_LAST_ONE;

    case (act_nxt)
      ACT_SHIFT: begin
        case (variant_r)
          VAR_THREE: begin
            case (ph)
              PH_START: begin
                if (lim1) begin
                  if (pos_r == 8'd0) begin
                    ds_nxt = 1'b1; act_nxt = ACT_NONE; phase_nxt = PH_START;
                  end else begin
                    act_nxt = ACT_RETURN; start_nxt = '0; ds_nxt = 1'b1; dr_nxt = 1'b0;
                  end
                end else begin
                  ds_nxt = 1'b0;
                  if (pos_r == 8'd0) begin
                    vl_nxt = 1'b1; vb_nxt = 1'b0; vs_nxt = 1'b1; phase_nxt = PH3_FINAL;
                  end else begin
                    vs_nxt = 1'b0; vb_nxt = 1'b1; phase_nxt = PH_BACKOFF;
                  end
                  start_nxt = start_r + 8'd1;
                end
              end
              PH_BACKOFF: if (!loc) phase_nxt = PH3_STOP_WAIT;
              PH3_STOP_WAIT: begin
                if (wd) begin
                  wc_nxt = '0; vb_nxt = 1'b0; vs_nxt = 1'b0; phase_nxt = PH3_RETRACT;
                end else wc_nxt = wc_nxt + 16'd1;
              end
              PH3_RETRACT: begin
                vl_nxt = 1'b0; phase_nxt = PH3_IDLE_WAIT;
              end
              PH3_IDLE_WAIT: begin
                if (wd) begin
                  wc_nxt = '0; vb_nxt = 1'b0; vs_nxt = 1'b1; phase_nxt = PH3_SEEK;
                end else wc_nxt = wc_nxt + 16'd1;
              end
              PH3_SEEK: if (loc) phase_nxt = PH3_LOC_WAIT;
              PH3_LOC_WAIT: begin
                // count only while the locate sensor is clear
                if (!loc) begin
                  if (wd) begin
                    wc_nxt = '0; vl_nxt = 1'b1; phase_nxt = PH3_FINAL;
                  end else wc_nxt = wc_nxt + 16'd1;
                end
              end
              PH3_FINAL: begin
                if (loc || lim1) begin
                  vb_nxt = 1'b1; vs_nxt = 1'b0; phase_nxt = PH3_BRAKE;
                end
              end
              PH3_BRAKE: begin
                if (wd) begin
                  wc_nxt = '0; vb_nxt = 1'b0; vs_nxt = 1'b1; phase_nxt = PH3_PUSH;
                end else wc_nxt = wc_nxt + 16'd1;
              end
              PH3_PUSH: begin
                if (loc || lim1) begin
                  pos_nxt = pos_r + 8'd1; ds_nxt = 1'b1;
                  act_nxt = ACT_NONE; phase_nxt = PH_START;
                end
              end
              default: begin
                act_nxt = ACT_NONE; phase_nxt = PH_START; wc_nxt = '0;
              end
            endcase
          end
          VAR_FOUR: begin
            case (ph)
              PH_START: begin
                if (lim1 && lim2) begin
                  if (pos_r == 8'd0) begin
                    ds_nxt = 1'b1; act_nxt = ACT_NONE; phase_nxt = PH_START;
                  end else begin
                    act_nxt = ACT_RETURN; start_nxt = '0; ds_nxt = 1'b1; dr_nxt = 1'b0;
                  end
                end else begin
                  ds_nxt = 1'b0;
                  if (pos_r == 8'd0) begin
                    vl_nxt = 1'b1; vs_nxt = 1'b1; phase_nxt = PH4_LIM1;
                  end else begin
                    vs_nxt = 1'b0; phase_nxt = PH4_LIM2_FALL;
                  end
                  start_nxt = start_r + 8'd1;
                end
              end
              PH4_LIM2_FALL: begin
                if (lim2_fall) begin
                  vl_nxt = 1'b0; vs_nxt = 1'b1; phase_nxt = PH4_LOCATE;
                end
              end
              PH4_LOCATE: begin
                if (loc) begin
                  vl_nxt = 1'b1; phase_nxt = PH4_LIM1;
                end
              end
              PH4_LIM1: begin
                if (lim1) begin
                  pos_nxt = pos_r + 8'd1; ds_nxt = 1'b1;
                  act_nxt = ACT_NONE; phase_nxt = PH_START;
                end
              end
              default: begin
                act_nxt = ACT_NONE; phase_nxt = PH_START; wc_nxt = '0;
              end
            endcase
          end
          VAR_TWO: begin
            case (ph)
              PH_START: begin
                ds_nxt = 1'b0;
                if (!loc && pos_r == 8'd0) begin
                  vl_nxt = 1'b1; vs_nxt = 1'b1; phase_nxt = PH2_LOCATE;
                  start_nxt = start_r + 8'd1;
                end else if (pos_r == 8'd0) begin
                  ds_nxt = 1'b1; act_nxt = ACT_NONE; phase_nxt = PH_START;
                end else begin
                  act_nxt = ACT_RETURN; start_nxt = '0; ds_nxt = 1'b1; dr_nxt = 1'b0;
                end
              end
              PH2_LOCATE: begin
                if (loc) begin
                  pos_nxt = pos_r + 8'd1; ds_nxt = 1'b1;
                  act_nxt = ACT_NONE; phase_nxt = PH_START;
                end
              end
              default: begin
                act_nxt = ACT_NONE; phase_nxt = PH_START; wc_nxt = '0;
              end
            endcase
          end
          default: begin
            case (ph)
              PH_START: begin
                ds_nxt = 1'b0; vl_nxt = 1'b1; vb_nxt = 1'b0; vs_nxt = 1'b1;
                phase_nxt = PHO_COUNT;
                start_nxt = start_r + 8'd1;
              end
              PHO_COUNT: begin
                pos_nxt = pos_r + 8'd1; ds_nxt = 1'b1;
                act_nxt = ACT_NONE; phase_nxt = PH_START;
              end
              default: begin
                act_nxt = ACT_NONE; phase_nxt = PH_START; wc_nxt = '0;
              end
            endcase
          end
        endcase
      end
      ACT_RETURN: begin
        case (ph)
          PH_START: begin
            dr_nxt    = 1'b0;
            phase_nxt = (lim1 || origin) ? PHR_RETRACT : PHR_FALL;
            vs_nxt    = 1'b0;
            start_nxt = '0;
          end
          PHR_FALL: if (loc_fall) phase_nxt = PHR_RETRACT;
          PHR_RETRACT: begin
            vl_nxt = 1'b0; phase_nxt = PHR_ORIGIN;
          end
          PHR_ORIGIN: begin
            if (origin) begin
              pos_nxt = '0; dr_nxt = 1'b1; act_nxt = ACT_NONE; phase_nxt = PH_START;
            end
          end
          default: begin
            act_nxt = ACT_NONE; phase_nxt = PH_START; wc_nxt = '0;
          end
        endcase
      end
      ACT_SR, ACT_SR2: begin
        if (variant_r != VAR_TWO || ph > sr_last) begin
          act_nxt = ACT_NONE; phase_nxt = PH_START; wc_nxt = '0;
        end else begin
          case (ph[1:0])
            2'd0: begin
              if (ph == PH_START) begin
                if (act_nxt == ACT_SR) dsr_nxt = 1'b0;
                else dsr2_nxt = 1'b0;
              end
              vl_nxt = 1'b1; vs_nxt = 1'b1; phase_nxt = ph + 5'd1;
            end
            2'd1: if (loc) phase_nxt = ph + 5'd1;
            2'd2: begin
              vs_nxt = 1'b0; phase_nxt = ph + 5'd1;
            end
            default: begin
              if (origin) begin
                if (ph == sr_last) begin
                  if (act_nxt == ACT_SR) dsr_nxt = 1'b1;
                  else dsr2_nxt = 1'b1;
                  act_nxt = ACT_NONE; phase_nxt = PH_START;
                end else phase_nxt = ph + 5'd1;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r  <= VAR_THREE;
      rl_delay_r <= '0;
      ri_delay_r <= '0;
      sl_delay_r <= '0;
      ss_delay_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VARIANT:      variant_r  <= cfg_wdata[1:0];
        CFG_RET_LOC_DLY:  rl_delay_r <= cfg_wdata;
        CFG_RET_IDLE_DLY: ri_delay_r <= cfg_wdata;
        CFG_SHF_LOC_DLY:  sl_delay_r <= cfg_wdata;
        CFG_SHF_STOP_DLY: ss_delay_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // stage valids and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      phase_r     <= PH_START;
      act_r       <= ACT_NONE;
      wc_r        <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      vs_r        <= 1'b0;
      vb_r        <= 1'b0;
      vl_r        <= 1'b0;
      ds_r        <= 1'b0;
      dr_r        <= 1'b0;
      dsr_r       <= 1'b0;
      dsr2_r      <= 1'b0;
      prev_loc_r  <= 1'b0;
      prev_lim2_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (adv) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (adv) begin
        phase_r     <= phase_nxt;
        act_r       <= act_nxt;
        wc_r        <= wc_nxt;
        pos_r       <= pos_nxt;
        start_r     <= start_nxt;
        vs_r        <= vs_nxt;
        vb_r        <= vb_nxt;
        vl_r        <= vl_nxt;
        ds_r        <= ds_nxt;
        dr_r        <= dr_nxt;
        dsr_r       <= dsr_nxt;
        dsr2_r      <= dsr2_nxt;
        prev_loc_r  <= loc;
        prev_lim2_r <= lim2;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_data_r <= in_tdata[6:0];
    if (adv) begin
      out_data_r <= {start_nxt, pos_nxt, dsr2_nxt, dsr_nxt, dr_nxt, ds_nxt,
                     (act_nxt != ACT_NONE), vl_nxt, vb_nxt, vs_nxt};
    end
  end

  `PSRS_ASSERT(a_idle_phase, act_r == ACT_NONE, phase_r == PH_START, "idle with nonzero phase")
  `PSRS_ASSERT(a_phase_range, 1'b1, phase_r <= PH_BACKOFF, "phase out of range")
  `PSRS_ASSERT(a_ready_empty, !out_v_r, in_tready, "input stalled with empty result register")
  `PSRS_ASSERT_NXT(a_hold_in, in_v_r && out_v_r && !out_tready, in_v_r, "stalled input beat lost")

endmodule
